>>> sv/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   position;
		logic [DATA_W-1:0]  value;
	} in_word_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   read_data;
		logic [COUNT_W-1:0]  count;
	} out_word_t;

	typedef struct packed {
		logic               ins;
		logic               upd;
		logic               rem;
		logic [POS_W-1:0]   pos;
	} cell_ctrl_t;

endpackage

>>> sv/positional_list_store_unit.sv
// Top level of the positional list store: control, count and a row of element cells.
//
// Usage:
//   in_word (kind, position, value) enters on in_valid/in_ready. Each word
//   is read, insert, update or remove of the element at position.
//   out_word (status, read_data, count) leaves on out_valid/out_ready, one
//   result word for every input word, in order.
//   The result of a word accepted at one edge is registered and presented
//   from the next edge. Throughput is one word per cycle while the receiver
//   does not stall; every request finishes in the cycle in which the row of
//   cells shifts all elements at once toward or away from the addressed position.
//   The output register decouples the two sides: a new word is taken while
//   a result is waiting only if out_ready takes that result in the same
//   cycle. While the receiver stalls, in_ready stays low and the result
//   holds.
//   Reset clears the element count and the output valid flag. Element
//   cells are not cleared; only positions below the count are readable.
module positional_list_store_unit #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pls_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pls_pkg::out_word_t   out_word
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;
	localparam int EXT_W = (ELEMENT_WIDTH > pls_pkg::DATA_W) ? ELEMENT_WIDTH : pls_pkg::DATA_W;

	logic                       accept;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           cnt_next;
	logic [CMP_W-1:0]           pos_x;
	logic [CMP_W-1:0]           cnt_x;
	logic                       in_range;
	logic                       in_gap;
	logic                       full;
	pls_pkg::status_t           status;
	pls_pkg::cell_ctrl_t        ctrl;
	logic [ELEMENT_WIDTH-1:0]   value_e;
	logic [ELEMENT_WIDTH-1:0]   cell_data [CAPACITY];
	logic [ELEMENT_WIDTH-1:0]   read_term [CAPACITY];
	logic [ELEMENT_WIDTH-1:0]   read_or;
	logic [EXT_W-1:0]           read_ext;
	logic                       out_valid_q;
	pls_pkg::out_word_t         out_word_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign pos_x    = CMP_W'(in_word.position);
	assign cnt_x    = CMP_W'(cnt_q);
	assign in_range = (pos_x < cnt_x);
	assign in_gap   = (pos_x <= cnt_x);
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign value_e  = ELEMENT_WIDTH'(EXT_W'(in_word.value));

	always_comb begin
		status = pls_pkg::ST_OK;
		unique case (in_word.kind)
			pls_pkg::KIND_READ, pls_pkg::KIND_UPDATE, pls_pkg::KIND_REMOVE: begin
				if (!in_range) begin
					status = pls_pkg::ST_BAD_INDEX;
				end
			end
			pls_pkg::KIND_INSERT: begin
				priority if (!in_gap) begin
					status = pls_pkg::ST_BAD_INDEX;
				end else if (full) begin
					status = pls_pkg::ST_FULL;
				end else begin
					status = pls_pkg::ST_OK;
				end
			end
			default: status = pls_pkg::ST_BAD_INDEX;
		endcase
	end

	always_comb begin
		ctrl.pos = in_word.position;
		ctrl.ins = accept && (in_word.kind == pls_pkg::KIND_INSERT)
			&& (status == pls_pkg::ST_OK);
		ctrl.upd = accept && (in_word.kind == pls_pkg::KIND_UPDATE)
			&& (status == pls_pkg::ST_OK);
		ctrl.rem = accept && (in_word.kind == pls_pkg::KIND_REMOVE)
			&& (status == pls_pkg::ST_OK);
	end

	always_comb begin
		priority if (ctrl.ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [ELEMENT_WIDTH-1:0] left_d;
			logic [ELEMENT_WIDTH-1:0] right_d;
			if (g == 0) begin : g_first
				assign left_d = cell_data[g];
			end else begin : g_mid_l
				assign left_d = cell_data[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_d = cell_data[g];
			end else begin : g_mid_r
				assign right_d = cell_data[g+1];
			end
			pls_cell #(
				.INDEX         (g),
				.CAPACITY      (CAPACITY),
				.ELEMENT_WIDTH (ELEMENT_WIDTH)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.value      (value_e),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[g]),
				.read_term  (read_term[g])
			);
		end
	endgenerate

	always_comb begin
		read_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_or = read_or | read_term[i];
		end
	end

	assign read_ext = EXT_W'(read_or);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q.status    <= status;
			out_word_q.count     <= pls_pkg::COUNT_W'(cnt_next);
			out_word_q.read_data <= ((in_word.kind == pls_pkg::KIND_READ)
				&& (status == pls_pkg::ST_OK)) ? read_ext[pls_pkg::DATA_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("remove did not shrink the count");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_word_q.status != pls_pkg::ST_OK)) |-> (out_word_q.read_data == '0))
		else $error("failed request carries read data");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

>>> sv/pls_cell.sv
// One storage cell of the list: holds one element and shifts to or from its neighbors.
module pls_cell #(
	parameter int INDEX         = 0,
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                      clk,
	input  pls_pkg::cell_ctrl_t       ctrl,
	input  logic [ELEMENT_WIDTH-1:0]  value,
	input  logic [ELEMENT_WIDTH-1:0]  left_data,
	input  logic [ELEMENT_WIDTH-1:0]  right_data,
	output logic [ELEMENT_WIDTH-1:0]  data,
	output logic [ELEMENT_WIDTH-1:0]  read_term
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (IDX_W > pls_pkg::POS_W) ? IDX_W : pls_pkg::POS_W;

	logic [CMP_W-1:0]          pos_x;
	logic [CMP_W-1:0]          idx_x;
	logic                      hit;
	logic                      above;
	logic [ELEMENT_WIDTH-1:0]  data_q;

	assign pos_x = CMP_W'(ctrl.pos);
	assign idx_x = CMP_W'(INDEX);
	assign hit   = (pos_x == idx_x);
	assign above = (idx_x > pos_x);

	always_ff @(posedge clk) begin
		priority if (ctrl.ins && hit) begin
			data_q <= value;
		end else if (ctrl.ins && above) begin
			data_q <= left_data;
		end else if (ctrl.upd && hit) begin
			data_q <= value;
		end else if (ctrl.rem && (hit || above)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data      = data_q;
	assign read_term = hit ? data_q : '0;

endmodule
